// ----- hw/rtl/stp_pkg.sv -----
// Package with shared types and constants of the software timer pool.
`timescale 1ns / 1ps
`default_nettype none
package stp_pkg;
	localparam int NUM_TIMERS = 16;
	localparam int ID_W = 4;
	localparam int CNT_W = 5;

	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_CREATE = 3'd1;
	localparam logic [2:0] KIND_DELETE = 3'd2;
	localparam logic [2:0] KIND_START = 3'd3;
	localparam logic [2:0] KIND_STOP = 3'd4;

	localparam logic [1:0] TS_UNUSED = 2'd0;
	localparam logic [1:0] TS_STOPPED = 2'd1;
	localparam logic [1:0] TS_RUNNING = 2'd2;
	localparam logic [1:0] TS_COMPLETED = 2'd3;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_BAD_PERIOD = 3'd1;
	localparam logic [2:0] STAT_BAD_DELAY = 3'd2;
	localparam logic [2:0] STAT_BAD_OPTION = 3'd3;
	localparam logic [2:0] STAT_NONE_FREE = 3'd4;
	localparam logic [2:0] STAT_INACTIVE = 3'd5;
	localparam logic [2:0] STAT_NO_CALLBACK = 3'd6;
	localparam logic [2:0] STAT_BAD_ID = 3'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] timer_id;
		logic [31:0] first_delay;
		logic [31:0] repeat_period;
		logic [1:0] option;
		logic has_callback;
		logic [31:0] user_tag;
	} cmd_t;

	typedef struct packed {
		logic event_res;
		logic [3:0] result_timer;
		logic success;
		logic [2:0] status;
		logic callback_fired;
		logic [31:0] result_tag;
		logic [4:0] free_count;
		logic last;
	} res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/stp_front.sv -----
// Front end: accepts commands and queues those that have work to do.
`timescale 1ns / 1ps
`default_nettype none
module stp_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire stp_pkg::cmd_t cmd,
	output logic busy,
	output logic q_valid,
	output stp_pkg::cmd_t q_cmd,
	input wire logic q_pop
);
	import stp_pkg::*;

	// Two-entry queue toward the back end.
	cmd_t mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	// Unknown kinds are dropped here.
	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy && (cmd.kind <= KIND_STOP);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/stp_back.sv -----
// Back end: timer table, free stack and tick scan.
`timescale 1ns / 1ps
`default_nettype none
module stp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire stp_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic res_valid,
	output stp_pkg::res_t res
);
	import stp_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN} state_t;

	state_t state_q;
	logic [31:0] now_q;
	logic [31:0] match_q [NUM_TIMERS];
	logic [31:0] delay_q [NUM_TIMERS];
	logic [31:0] period_q [NUM_TIMERS];
	logic [31:0] tag_q [NUM_TIMERS];
	logic [1:0] tstate_q [NUM_TIMERS];
	logic periodic_q [NUM_TIMERS];
	logic cb_q [NUM_TIMERS];
	logic [ID_W-1:0] stack_q [NUM_TIMERS];
	logic [CNT_W-1:0] depth_q;
	logic [ID_W-1:0] idx_q;

	logic more;
	logic hit;
	logic [2:0] cr_st;
	logic [ID_W-1:0] cr_t;
	res_t res_n;
	logic res_v_n;

	// Look ahead for another expiry after the current index.
	always_comb begin
		more = 1'b0;
		for (int j = 0; j < NUM_TIMERS; j++) begin
			if (ID_W'(j) > idx_q && tstate_q[j] == TS_RUNNING && match_q[j] == now_q)
				more = 1'b1;
		end
	end

	assign q_pop = q_valid && (state_q == S_IDLE);

	assign hit = tstate_q[idx_q] == TS_RUNNING && match_q[idx_q] == now_q;

	// Create validation and the timer on top of the free stack.
	always_comb begin
		cr_st = STAT_OK;
		cr_t = stack_q[depth_q[ID_W-1:0] - ID_W'(1)];
		if (q_cmd.option == 2'd0) begin
			if (q_cmd.repeat_period == '0) cr_st = STAT_BAD_PERIOD;
		end else if (q_cmd.option == 2'd1) begin
			if (q_cmd.first_delay == '0) cr_st = STAT_BAD_DELAY;
		end else begin
			cr_st = STAT_BAD_OPTION;
		end
		if (cr_st == STAT_OK && depth_q == '0) cr_st = STAT_NONE_FREE;
	end

	// Result transaction for the command being taken or the timer being scanned.
	always_comb begin
		res_n = '0;
		res_v_n = 1'b0;
		if (q_pop) begin
			res_n.last = 1'b1;
			if (q_cmd.kind == KIND_TICK) begin
				res_v_n = 1'b0;
			end else if (q_cmd.kind == KIND_CREATE) begin
				res_v_n = 1'b1;
				res_n.status = cr_st;
				res_n.free_count = depth_q;
				if (cr_st == STAT_OK) begin
					res_n.free_count = depth_q - 1'b1;
					res_n.success = 1'b1;
					res_n.result_timer = cr_t;
				end
			end else begin
				res_v_n = 1'b1;
				res_n.result_timer = q_cmd.timer_id;
				res_n.free_count = depth_q;
				if (tstate_q[q_cmd.timer_id] == TS_UNUSED) begin
					res_n.status = STAT_INACTIVE;
				end else if (q_cmd.kind == KIND_DELETE) begin
					res_n.success = 1'b1;
					if (depth_q < CNT_W'(NUM_TIMERS)) res_n.free_count = depth_q + 1'b1;
				end else if (q_cmd.kind == KIND_START) begin
					res_n.success = 1'b1;
				end else begin
					res_n.success = 1'b1;
					if (tstate_q[q_cmd.timer_id] == TS_RUNNING) begin
						if (q_cmd.option == 2'd1 || q_cmd.option == 2'd2) begin
							if (cb_q[q_cmd.timer_id]) begin
								res_n.callback_fired = 1'b1;
								res_n.result_tag = (q_cmd.option == 2'd1) ?
									tag_q[q_cmd.timer_id] : q_cmd.user_tag;
							end else begin
								res_n.status = STAT_NO_CALLBACK;
							end
						end else if (q_cmd.option == 2'd3) begin
							res_n.status = STAT_BAD_OPTION;
						end
					end
				end
			end
		end else if (state_q == S_SCAN && hit) begin
			// An expiry is reported with whether more follow.
			res_v_n = 1'b1;
			res_n.event_res = 1'b1;
			res_n.result_timer = idx_q;
			res_n.callback_fired = cb_q[idx_q];
			res_n.result_tag = cb_q[idx_q] ? tag_q[idx_q] : '0;
			res_n.free_count = depth_q;
			res_n.last = !more;
		end
	end

	// Command execution and scan sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= '0;
			depth_q <= CNT_W'(NUM_TIMERS);
			idx_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
			for (int j = 0; j < NUM_TIMERS; j++) begin
				match_q[j] <= '0;
				delay_q[j] <= '0;
				period_q[j] <= '0;
				tag_q[j] <= '0;
				tstate_q[j] <= TS_UNUSED;
				periodic_q[j] <= 1'b0;
				cb_q[j] <= 1'b0;
				stack_q[j] <= ID_W'(NUM_TIMERS - 1 - j);
			end
		end else begin
			res_valid <= res_v_n;
			res <= res_n;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_cmd.kind == KIND_TICK) begin
							now_q <= now_q + 32'd1;
							idx_q <= '0;
							state_q <= S_SCAN;
						end else if (q_cmd.kind == KIND_CREATE) begin
							if (cr_st == STAT_OK) begin
								depth_q <= depth_q - 1'b1;
								tstate_q[cr_t] <= TS_STOPPED;
								delay_q[cr_t] <= q_cmd.first_delay;
								period_q[cr_t] <= q_cmd.repeat_period;
								periodic_q[cr_t] <= (q_cmd.option == 2'd0);
								cb_q[cr_t] <= q_cmd.has_callback;
								tag_q[cr_t] <= q_cmd.user_tag;
							end
						end else if (tstate_q[q_cmd.timer_id] != TS_UNUSED) begin
							if (q_cmd.kind == KIND_DELETE) begin
								tstate_q[q_cmd.timer_id] <= TS_UNUSED;
								period_q[q_cmd.timer_id] <= '0;
								match_q[q_cmd.timer_id] <= '0;
								periodic_q[q_cmd.timer_id] <= 1'b0;
								cb_q[q_cmd.timer_id] <= 1'b0;
								if (depth_q < CNT_W'(NUM_TIMERS)) begin
									stack_q[depth_q[ID_W-1:0]] <= q_cmd.timer_id;
									depth_q <= depth_q + 1'b1;
								end
							end else if (q_cmd.kind == KIND_START) begin
								tstate_q[q_cmd.timer_id] <= TS_RUNNING;
								match_q[q_cmd.timer_id] <= now_q +
									((delay_q[q_cmd.timer_id] == '0) ?
									period_q[q_cmd.timer_id] : delay_q[q_cmd.timer_id]);
							end else if (tstate_q[q_cmd.timer_id] == TS_RUNNING) begin
								tstate_q[q_cmd.timer_id] <= TS_STOPPED;
							end
						end
					end
				end
				S_SCAN: begin
					// One timer per cycle; periodic timers re-arm, one-shot timers complete.
					if (hit) begin
						if (periodic_q[idx_q]) match_q[idx_q] <= now_q + period_q[idx_q];
						else tstate_q[idx_q] <= TS_COMPLETED;
					end
					if (idx_q == ID_W'(NUM_TIMERS - 1) || (!more)) state_q <= S_IDLE;
					idx_q <= idx_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/software_timer_pool_core.sv -----
// Top level of the software timer pool.
// A command reply passes through the two-entry queue and the registered result ports, and
// waits longer when the back end is still scanning for an earlier tick.
// Throughput: one command per cycle while busy is low; a tick holds the back end while it
// is taken and while the scan runs, one timer a cycle. busy rises when the
// two-entry queue is full. The receiver cannot stall.
// Reset clears all timers to unused and refills the free stack with timer 0 on top.
`timescale 1ns / 1ps
`default_nettype none
module software_timer_pool_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire stp_pkg::cmd_t cmd,
	output logic busy,
	output logic res_valid,
	output stp_pkg::res_t res
);
	import stp_pkg::*;

	logic q_valid, q_pop, fbusy;
	cmd_t q_cmd;

	assign busy = fbusy;

	stp_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(fbusy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	stp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_pop(q_pop), .res_valid(res_valid), .res(res)
	);
endmodule
`default_nettype wire

// ----- tb/sv/tb_software_timer_pool_core.sv -----
// Self-checking testbench of the software timer pool core.
`timescale 1ns / 1ps
`default_nettype none
module tb_software_timer_pool_core;
	import stp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM = 360;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic res_valid;
	res_t res;

	software_timer_pool_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.res_valid(res_valid),
		.res(res)
	);

	// Shadow copy of the pool state.
	logic [31:0] now_ticks;
	logic [31:0] match_q [NUM_TIMERS];
	logic [31:0] delay_q [NUM_TIMERS];
	logic [31:0] period_q [NUM_TIMERS];
	logic [1:0] state_q [NUM_TIMERS];
	logic periodic_q [NUM_TIMERS];
	logic cb_q [NUM_TIMERS];
	logic [31:0] tag_q [NUM_TIMERS];
	logic [3:0] free_stack [NUM_TIMERS];
	logic [4:0] free_depth;

	res_t pending_results [$];
	int mismatches;
	int cycles;
	int sender_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[software_timer_pool_core] ERROR");
			$finish;
		end
	end

	task automatic pool_reset();
		now_ticks = '0;
		free_depth = 5'(NUM_TIMERS);
		for (int i = 0; i < NUM_TIMERS; i++) begin
			match_q[i] = '0;
			delay_q[i] = '0;
			period_q[i] = '0;
			state_q[i] = TS_UNUSED;
			periodic_q[i] = 1'b0;
			cb_q[i] = 1'b0;
			tag_q[i] = '0;
			free_stack[i] = 4'(NUM_TIMERS - 1 - i);
		end
	endtask

	function automatic res_t mk_res(logic ev, logic [3:0] t, logic ok, logic [2:0] st,
			logic fired, logic [31:0] tag);
		res_t r;
		r.event_res = ev;
		r.result_timer = t;
		r.success = ok;
		r.status = st;
		r.callback_fired = fired;
		r.result_tag = fired ? tag : 32'd0;
		r.free_count = free_depth;
		r.last = 1'b0;
		return r;
	endfunction

	// Advance the shadow pool by one command and queue the results it causes.
	task automatic predict_pool(input cmd_t c);
		res_t r;
		int n;
		logic [2:0] st;
		logic [3:0] t;
		logic ok;
		logic fired;
		logic [31:0] rtag;
		n = 0;
		if (c.kind == KIND_TICK) begin
			now_ticks = now_ticks + 32'd1;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (state_q[i] == TS_RUNNING && match_q[i] == now_ticks) begin
					if (periodic_q[i]) match_q[i] = now_ticks + period_q[i];
					else state_q[i] = TS_COMPLETED;
					pending_results.push_back(mk_res(1'b1, 4'(i), 1'b0, STAT_OK, cb_q[i],
						tag_q[i]));
					n++;
				end
			end
		end else if (c.kind == KIND_CREATE) begin
			st = STAT_OK;
			t = '0;
			if (c.option == 2'd0) begin
				if (c.repeat_period == 0) st = STAT_BAD_PERIOD;
			end else if (c.option == 2'd1) begin
				if (c.first_delay == 0) st = STAT_BAD_DELAY;
			end else begin
				st = STAT_BAD_OPTION;
			end
			if (st == STAT_OK && free_depth == 0) st = STAT_NONE_FREE;
			if (st == STAT_OK) begin
				free_depth = free_depth - 5'd1;
				t = free_stack[free_depth[3:0]];
				state_q[t] = TS_STOPPED;
				delay_q[t] = c.first_delay;
				period_q[t] = c.repeat_period;
				periodic_q[t] = (c.option == 2'd0);
				cb_q[t] = c.has_callback;
				tag_q[t] = c.user_tag;
			end
			pending_results.push_back(mk_res(1'b0, t, st == STAT_OK, st, 1'b0, 32'd0));
			n = 1;
		end else if (c.kind <= KIND_STOP) begin
			ok = 1'b0;
			st = STAT_OK;
			fired = 1'b0;
			rtag = '0;
			t = c.timer_id;
			if (state_q[t] == TS_UNUSED) begin
				st = STAT_INACTIVE;
			end else if (c.kind == KIND_DELETE) begin
				state_q[t] = TS_UNUSED;
				period_q[t] = '0;
				match_q[t] = '0;
				periodic_q[t] = 1'b0;
				cb_q[t] = 1'b0;
				if (free_depth < NUM_TIMERS) begin
					free_stack[free_depth[3:0]] = t;
					free_depth = free_depth + 5'd1;
				end
				ok = 1'b1;
			end else if (c.kind == KIND_START) begin
				state_q[t] = TS_RUNNING;
				match_q[t] = now_ticks + ((delay_q[t] == 0) ? period_q[t] : delay_q[t]);
				ok = 1'b1;
			end else begin
				ok = 1'b1;
				if (state_q[t] == TS_RUNNING) begin
					state_q[t] = TS_STOPPED;
					if (c.option == 2'd1 || c.option == 2'd2) begin
						if (cb_q[t]) begin
							fired = 1'b1;
							rtag = (c.option == 2'd1) ? tag_q[t] : c.user_tag;
						end else begin
							st = STAT_NO_CALLBACK;
						end
					end else if (c.option == 2'd3) begin
						st = STAT_BAD_OPTION;
					end
				end
			end
			pending_results.push_back(mk_res(1'b0, t, ok, st, fired, rtag));
			n = 1;
		end
		if (n > 0) begin
			r = pending_results.pop_back();
			r.last = 1'b1;
			pending_results.push_back(r);
		end
	endtask

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", res);
			end else begin
				if (pending_results[0] !== res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", pending_results[0], res);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	function automatic cmd_t mk_cmd(logic [2:0] k, logic [3:0] id, logic [31:0] d,
			logic [31:0] p, logic [1:0] o, logic cb, logic [31:0] tag);
		cmd_t c;
		c.kind = k;
		c.timer_id = id;
		c.first_delay = d;
		c.repeat_period = p;
		c.option = o;
		c.has_callback = cb;
		c.user_tag = tag;
		return c;
	endfunction

	// Present one command transaction at a falling edge and wait until it is taken.
	task automatic send_cmd(input cmd_t c);
		int gap;
		@(negedge clk);
		if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_pool(c);
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		logic [127:0] raw;
		int sel;
		raw = {$urandom, $urandom, $urandom, $urandom};
		c = cmd_t'(raw[$bits(cmd_t)-1:0]);
		sel = $urandom_range(99);
		if (sel < 35) c.kind = KIND_TICK;
		else if (sel < 52) c.kind = KIND_CREATE;
		else if (sel < 60) c.kind = KIND_DELETE;
		else if (sel < 80) c.kind = KIND_START;
		else if (sel < 95) c.kind = KIND_STOP;
		else c.kind = 3'($urandom_range(5, 7));
		// Short delays and periods so that timers actually expire.
		if ($urandom_range(9) < 8) begin
			c.first_delay = $urandom_range(0, 6);
			c.repeat_period = $urandom_range(0, 6);
			c.option = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : c.option;
		end
		return c;
	endfunction

	// Directed rows: command, whether a reply is typed in, and that reply.
	typedef struct {
		cmd_t c;
		logic check;
		res_t r;
	} row_t;

	row_t rows [$];

	task automatic add_row(input cmd_t c, input logic chk, input res_t r);
		row_t w;
		w.c = c;
		w.check = chk;
		w.r = r;
		rows.push_back(w);
	endtask

	initial begin
		res_t r0;
		res_t ex;
		mismatches = 0;
		cycles = 0;
		sender_idle = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		pool_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		r0 = '0;
		r0.last = 1'b1;
		// Stop on an unused timer right after reset.
		ex = r0; ex.result_timer = 4'd15; ex.status = STAT_INACTIVE; ex.free_count = 5'd16;
		add_row(mk_cmd(KIND_STOP, 4'd15, '1, '1, 2'd3, 1'b1, '1), 1'b1, ex);
		ex = r0; ex.status = STAT_BAD_PERIOD; ex.free_count = 5'd16;
		add_row(mk_cmd(KIND_CREATE, 4'd0, 32'd5, 32'd0, 2'd0, 1'b1, '1), 1'b1, ex);
		ex = r0; ex.status = STAT_BAD_DELAY; ex.free_count = 5'd16;
		add_row(mk_cmd(KIND_CREATE, 4'd0, 32'd0, '1, 2'd1, 1'b0, 32'd0), 1'b1, ex);
		ex = r0; ex.status = STAT_BAD_OPTION; ex.free_count = 5'd16;
		add_row(mk_cmd(KIND_CREATE, 4'd0, 32'd1, 32'd1, 2'd2, 1'b0, 32'd0), 1'b1, ex);
		ex = r0; ex.success = 1'b1; ex.free_count = 5'd15;
		add_row(mk_cmd(KIND_CREATE, 4'd0, 32'd0, 32'd2, 2'd0, 1'b1, 32'hA5A5_0001), 1'b1, ex);
		add_row(mk_cmd(KIND_CREATE, 4'd0, 32'd1, 32'd0, 2'd1, 1'b1, '1), 1'b0, r0);
		add_row(mk_cmd(KIND_CREATE, 4'd0, '1, '1, 2'd0, 1'b0, 32'd7), 1'b0, r0);
		add_row(mk_cmd(KIND_START, 4'd0, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_START, 4'd1, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_START, 4'd2, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_TICK, 4'd0, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_TICK, 4'd0, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(3'd6, 4'd3, '1, '1, 2'd3, 1'b1, '1), 1'b0, r0);
		add_row(mk_cmd(KIND_STOP, 4'd0, '0, '0, 2'd2, 1'b0, 32'h1234_5678), 1'b0, r0);
		add_row(mk_cmd(KIND_START, 4'd0, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_STOP, 4'd0, '0, '0, 2'd1, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_STOP, 4'd0, '0, '0, 2'd1, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_STOP, 4'd2, '0, '0, 2'd3, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_DELETE, 4'd1, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_DELETE, 4'd1, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);
		add_row(mk_cmd(KIND_CREATE, 4'd0, 32'd3, 32'd1, 2'd1, 1'b0, 32'd9), 1'b0, r0);
		add_row(mk_cmd(3'd7, 4'd0, '0, '0, 2'd0, 1'b0, '0), 1'b0, r0);

		foreach (rows[i]) begin
			send_cmd(rows[i].c);
			if (rows[i].check && pending_results.size() > 0
					&& pending_results[$] !== rows[i].r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: table %p, predicted %p", i, rows[i].r,
						pending_results[$]);
			end
		end

		// Random part in idling phases.
		for (int i = 0; i < N_RANDOM; i++) begin
			case ((i * 4) / N_RANDOM)
				0: sender_idle = 0;
				1: sender_idle = 88;
				2: sender_idle = 18;
				default: sender_idle = 0;
			endcase
			// Fill the pool once, at iteration 300, to reach the empty free stack.
			if (i == 300) begin
				for (int k = 0; k < 17; k++)
					send_cmd(mk_cmd(KIND_CREATE, 4'($urandom), 32'd2, 32'd3, 2'd0, 1'b1,
						$urandom));
				for (int k = 0; k < 16; k++)
					send_cmd(mk_cmd(KIND_START, 4'(k), '0, '0, 2'd0, 1'b0, '0));
				for (int k = 0; k < 6; k++)
					send_cmd(mk_cmd(KIND_TICK, 4'd0, '0, '0, 2'd0, 1'b0, '0));
			end
			send_cmd(random_cmd());
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[software_timer_pool_core] OK");
		end else begin
			$display("[software_timer_pool_core] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/stp_pkg.sv
hw/rtl/stp_front.sv
hw/rtl/stp_back.sv
hw/rtl/software_timer_pool_core.sv
tb/sv/tb_software_timer_pool_core.sv
